/* rtl/pli_pkg.sv */
// Shared types and constants for the positional list unit.
// No dependencies; used by every other file of the block.
`default_nettype none

package pli_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int OP_W   = 2;

    localparam logic [POS_W-1:0] MAX_ENTRIES_RST = 7'd64;

    // Register index as decoded from paddr[2]
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_LOCATE = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FIN
    } state_t;

    // Broadcast from the control logic to every cell of the row
    typedef struct packed {
        cell_cmd_t         cmd;
        logic [POS_W-1:0]  pidx;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  len;
    } cell_bus_t;

endpackage

`default_nettype wire

/* rtl/pli_if.sv */
// Valid/ready channel interfaces for list operations and their results.
// Depends on pli_pkg for field widths.
`default_nettype none

interface pli_req_if;
    logic                                valid;
    logic                                ready;
    logic [pli_pkg::OP_W-1:0]            op;
    logic [pli_pkg::POS_W-1:0]           position;
    logic signed [pli_pkg::DATA_W-1:0]   value;

    modport source (output valid, op, position, value, input ready);
    modport sink   (input valid, op, position, value, output ready);
endinterface

interface pli_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                ok;
    logic signed [pli_pkg::DATA_W-1:0]   element;
    logic [pli_pkg::POS_W-1:0]           found_at;
    logic [pli_pkg::POS_W-1:0]           count;

    modport source (output valid, ok, element, found_at, count, input ready);
    modport sink   (input valid, ok, element, found_at, count, output ready);
endinterface

`default_nettype wire

/* rtl/pli_cell.sv */
// One list cell: holds the entry at a fixed index, shifts with its neighbors,
// compares against the search value. Depends on pli_pkg.
`default_nettype none

module pli_cell #(
    parameter int IDX = 0
) (
    input  wire logic                          clk,
    input  wire pli_pkg::cell_bus_t            bus,
    input  wire logic [pli_pkg::DATA_W-1:0]    left_data,
    input  wire logic [pli_pkg::DATA_W-1:0]    right_data,
    output logic      [pli_pkg::DATA_W-1:0]    data,
    output logic                               match,
    output logic      [pli_pkg::DATA_W-1:0]    rd_data
);
    import pli_pkg::*;

    localparam logic [31:0] IDX_W = 32'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic [31:0]       pidx_w;
    logic [31:0]       len_w;

    assign pidx_w = {25'd0, bus.pidx};
    assign len_w  = {25'd0, bus.len};

    always_comb
    begin
        data_next = data_reg;
        case (bus.cmd)
            CELL_INSERT:
            begin
                if (IDX_W == pidx_w)
                begin
                    data_next = bus.value;
                end
                else if (IDX_W > pidx_w)
                begin
                    data_next = left_data;
                end
            end
            CELL_DELETE:
            begin
                if (IDX_W >= pidx_w)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign match   = (data_reg == bus.value) && (IDX_W < len_w);
    assign rd_data = (IDX_W == pidx_w) ? data_reg : '0;

endmodule

`default_nettype wire

/* rtl/pli_regs.sv */
// APB-style configuration register block holding max_entries.
// Depends on pli_pkg.
`default_nettype none

module pli_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output logic      [pli_pkg::POS_W-1:0]     max_entries
);
    import pli_pkg::*;

    logic [POS_W-1:0] max_entries_reg;
    logic [POS_W-1:0] max_entries_next;
    logic             wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);

    always_comb
    begin
        max_entries_next = max_entries_reg;
        if (wr_en)
        begin
            max_entries_next = pwdata[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
        end
    end

    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_MAX_ENTRIES) ? {25'd0, max_entries_reg} : 32'd0;
    assign max_entries = max_entries_reg;

endmodule

`default_nettype wire

/* rtl/positional_list_insert_delete_unit.sv */
// Top level of the positional list unit: control FSM, row of list cells,
// result register. Depends on pli_pkg, pli_if, pli_cell and pli_regs.
// A request is accepted in ST_IDLE, the cells update in ST_EXEC and the result
// register loads in ST_FIN once free; a new request waits for ST_IDLE.
// The result register frees the row while a finished result awaits transfer.
// Reset: length 0, max_entries 64, channels idle; cell contents are not reset.
`default_nettype none

module positional_list_insert_delete_unit #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    pli_req_if.sink          req,
    pli_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import pli_pkg::*;

    localparam logic [POS_W-1:0] CAP7 = (CAPACITY > 127) ? 7'd127 : 7'(CAPACITY);

    // Control state
    state_t            state_reg;
    state_t            state_next;
    logic [POS_W-1:0]  len_reg;
    logic [POS_W-1:0]  len_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    // Captured request
    op_t               op_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] val_reg;

    // Cell update stage results
    logic                ok_reg;
    logic [DATA_W-1:0]   elem_reg;
    logic [CAPACITY-1:0] match_reg;

    // Output register
    logic              res_ok_reg;
    logic [DATA_W-1:0] res_elem_reg;
    logic [POS_W-1:0]  res_found_reg;
    logic [POS_W-1:0]  res_count_reg;

    logic [POS_W-1:0]    max_entries;
    logic [POS_W-1:0]    limit;
    logic                ins_ok;
    logic                pos_ok;
    logic                exec_ok;
    logic [DATA_W-1:0]   exec_elem;
    logic                out_free;
    logic                req_xfer;
    logic [CAPACITY-1:0] match_bits;
    logic [CAPACITY-1:0] match_low;
    logic [POS_W-1:0]    found_enc;
    logic [DATA_W-1:0]   rd_or;
    cell_bus_t           bus;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];

    pli_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .max_entries (max_entries)
    );

    assign limit    = (max_entries < CAP7) ? max_entries : CAP7;
    assign req_xfer = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign ins_ok = (pos_reg != '0) && ({1'b0, pos_reg} <= ({1'b0, len_reg} + 8'd1))
                    && (len_reg < limit);
    assign pos_ok = (pos_reg != '0) && (pos_reg <= len_reg);

    // Row of cells
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [DATA_W-1:0] left_d;
            logic [DATA_W-1:0] right_d;
            if (gi == 0)
            begin : g_first
                assign left_d = '0;
            end
            else
            begin : g_mid_l
                assign left_d = cell_data[gi-1];
            end
            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_d = '0;
            end
            else
            begin : g_mid_r
                assign right_d = cell_data[gi+1];
            end
            pli_cell #(.IDX(gi)) u_cell (
                .clk        (clk),
                .bus        (bus),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[gi]),
                .match      (match_bits[gi]),
                .rd_data    (cell_rd[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    // Lowest set match bit, then its 1-based position
    assign match_low = match_reg & (~match_reg + 1'b1);

    always_comb
    begin
        found_enc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (match_low[i])
            begin
                found_enc = found_enc | 7'(i + 1);
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req.ready = 1'b0;
        bus.cmd   = CELL_HOLD;
        bus.pidx  = pos_reg - 7'd1;
        bus.value = val_reg;
        bus.len   = len_reg;
        len_next  = len_reg;
        exec_ok   = 1'b0;
        exec_elem = '0;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_EXEC:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        exec_ok = ins_ok;
                        if (ins_ok)
                        begin
                            bus.cmd  = CELL_INSERT;
                            len_next = len_reg + 7'd1;
                        end
                    end
                    OP_DELETE:
                    begin
                        exec_ok = pos_ok;
                        if (pos_ok)
                        begin
                            bus.cmd   = CELL_DELETE;
                            len_next  = len_reg - 7'd1;
                            exec_elem = rd_or;
                        end
                    end
                    OP_GET:
                    begin
                        exec_ok = pos_ok;
                        if (pos_ok)
                        begin
                            exec_elem = rd_or;
                        end
                    end
                    default:
                    begin
                        exec_ok = 1'b0;
                    end
                endcase
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            op_reg  <= op_t'(req.op);
            pos_reg <= req.position;
            val_reg <= req.value;
        end
        if (state_reg == ST_EXEC)
        begin
            ok_reg    <= exec_ok;
            elem_reg  <= exec_elem;
            match_reg <= match_bits;
        end
        if ((state_reg == ST_FIN) && out_free)
        begin
            res_ok_reg    <= (op_reg == OP_LOCATE) ? (|match_reg) : ok_reg;
            res_elem_reg  <= elem_reg;
            res_found_reg <= (op_reg == OP_LOCATE) ? found_enc : '0;
            res_count_reg <= len_reg;
        end
    end

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.ok       = res_ok_reg;
    assign rsp.element  = res_elem_reg;
    assign rsp.found_at = res_found_reg;
    assign rsp.count    = res_count_reg;

    // Checks
    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= CAP7)
        else $error("list length above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer |=> (state_reg == ST_EXEC))
        else $error("accepted transfer did not start execution");

    a_insert_len: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EXEC) && (bus.cmd == CELL_INSERT))
        |=> (len_reg == $past(len_reg) + 7'd1))
        else $error("insert did not grow the list");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.found_at != '0)) |-> rsp.ok)
        else $error("found position without ok");

endmodule

`default_nettype wire

/* tb/tb_positional_list_insert_delete_unit.sv */
// Self-checking testbench for positional_list_insert_delete_unit: insert, delete,
// locate and get over valid/ready channels, max_entries set through the APB port.
// Depends on rtl/pli_pkg.sv, rtl/pli_if.sv and the unit's RTL.
`timescale 1ns / 100ps

import pli_pkg::*;

typedef struct packed {
    op_t                op;
    logic [6:0]         position;
    logic signed [31:0] value;
} list_op_t;

typedef struct packed {
    logic               ok;
    logic signed [31:0] element;
    logic [6:0]         found_at;
    logic [6:0]         count;
} list_result_t;

class shadow_list;
    localparam int DEPTH = 64;

    logic signed [31:0] slots [DEPTH];
    int                 used;
    logic [6:0]         max_entries;
    list_result_t       pending_results [$];
    int unsigned        op_count [4];
    int unsigned        ok_count;
    int unsigned        checked;
    int unsigned        mismatches;
    int                 peak;

    function new();
        used = 0;
        peak = 0;
        max_entries = MAX_ENTRIES_RST;
        ok_count = 0;
        checked = 0;
        mismatches = 0;
        foreach (op_count[i]) op_count[i] = 0;
    endfunction

    function void write_config(logic index, logic [31:0] data);
        if (index == REG_MAX_ENTRIES)
            max_entries = data[6:0];
    endfunction

    function int entry_limit();
        return (max_entries < DEPTH) ? int'(max_entries) : DEPTH;
    endfunction

    function void apply_op(list_op_t item);
        list_result_t want;
        int pos;
        int j;
        pos = item.position;
        want = '0;
        op_count[int'(item.op)]++;
        case (item.op)
            OP_INSERT:
                if (pos >= 1 && pos <= used + 1 && used < entry_limit())
                begin
                    for (j = used; j >= pos; j--)
                        slots[j] = slots[j - 1];
                    slots[pos - 1] = item.value;
                    used++;
                    want.ok = 1'b1;
                end
            OP_DELETE:
                if (pos >= 1 && pos <= used)
                begin
                    want.element = slots[pos - 1];
                    for (j = pos; j < used; j++)
                        slots[j - 1] = slots[j];
                    used--;
                    want.ok = 1'b1;
                end
            OP_LOCATE:
                for (j = 0; j < used && !want.ok; j++)
                    if (slots[j] == item.value)
                    begin
                        want.ok = 1'b1;
                        want.found_at = 7'(j + 1);
                    end
            default:
                if (pos >= 1 && pos <= used)
                begin
                    want.element = slots[pos - 1];
                    want.ok = 1'b1;
                end
        endcase
        want.count = 7'(used);
        if (want.ok) ok_count++;
        if (used > peak) peak = used;
        pending_results.push_back(want);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h", $time, name, want, got);
        end
    endfunction

    function void match_result(logic ok, logic signed [31:0] element,
                               logic [6:0] found_at, logic [6:0] count);
        list_result_t want;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result ok=%0b element=%0d found_at=%0d count=%0d",
                     $time, ok, element, found_at, count);
            return;
        end
        want = pending_results.pop_front();
        checked++;
        check_field("ok", 32'(want.ok), 32'(ok));
        check_field("element", want.element, element);
        check_field("found_at", 32'(want.found_at), 32'(found_at));
        check_field("count", 32'(want.count), 32'(count));
    endfunction
endclass

module tb_positional_list_insert_delete_unit;

    localparam int    LIST_DEPTH     = 64;
    localparam int    SETTLE_CYCLES  = 6;
    localparam int    HOLD_CYCLES    = 80;
    localparam int    WATCHDOG_LIMIT = 2000;
    localparam logic  REG_UNUSED     = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_requests;
    int unsigned last_limit;

    shadow_list book = new();

    pli_req_if req_ch ();
    pli_rsp_if rsp_ch ();

    positional_list_insert_delete_unit #(
        .CAPACITY (LIST_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side: random stalls plus long hold-offs on request
    initial
    begin
        int unsigned holds_done;
        int          hold_left;
        holds_done = 0;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            book.match_result(rsp_ch.ok, rsp_ch.element, rsp_ch.found_at, rsp_ch.count);

    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stall = 0;
            else
                stall++;
            if (stall >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall);
                $display("FAIL positional_list_insert_delete_unit");
                $finish;
            end
        end
    end

    task automatic offer_op(input op_t op, input logic [6:0] position,
                            input logic signed [31:0] value);
        list_op_t item;
        item = '{op: op, position: position, value: value};
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.op       <= op;
        req_ch.position <= position;
        req_ch.value    <= value;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        book.apply_op(item);
    endtask

    task automatic wait_list_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (book.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input logic index, input logic [31:0] data);
        logic [2:0] addr;
        addr = {index, 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        book.write_config(index, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        if (index == REG_MAX_ENTRIES)
        begin
            psel <= 1'b1;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready) @(posedge clk);
            book.check_field("max_entries readback", {25'd0, book.max_entries}, prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(posedge clk);
            last_limit = book.max_entries;
        end
    endtask

    function automatic list_op_t next_random_op(int unsigned insert_pct);
        list_op_t    item;
        int unsigned len;
        int unsigned pick;
        len = book.used;
        pick = $urandom_range(99);
        if (pick < insert_pct)
            item.op = OP_INSERT;
        else
        begin
            pick = $urandom_range(2);
            item.op = (pick == 0) ? OP_DELETE : (pick == 1) ? OP_LOCATE : OP_GET;
        end
        if ($urandom_range(99) < 85)
            item.position = 7'($urandom_range(len + 1, 1));
        else
            item.position = 7'($urandom_range(127));
        case ($urandom_range(3))
            0: item.value = $signed(32'($urandom_range(8))) - 32'sd4;
            1: item.value = (len > 0) ? book.slots[$urandom_range(len - 1)] : $urandom;
            default: item.value = $urandom;
        endcase
        return item;
    endfunction

    // grows the list in alternate stretches and lets it shrink in between
    task automatic run_random(input int n, input int unsigned grow_pct,
                              input int hold_at, input int pause_at);
        list_op_t item;
        for (int i = 0; i < n; i++)
        begin
            if (i == hold_at) hold_requests++;
            if (i == pause_at) wait_list_idle();
            item = next_random_op(((i / 80) % 2 == 0) ? grow_pct : 25);
            offer_op(item.op, item.position, item.value);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.op      = OP_INSERT;
        req_ch.position = '0;
        req_ch.value   = '0;
        send_idle_pct  = 27;
        recv_idle_pct  = 84;
        hold_requests  = 0;
        last_limit     = MAX_ENTRIES_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, range edges, duplicates, extreme values
        offer_op(OP_GET,    7'd1,   32'sd0);
        offer_op(OP_DELETE, 7'd1,   32'sd0);
        offer_op(OP_LOCATE, 7'd0,   32'sd0);
        offer_op(OP_INSERT, 7'd0,   32'sd5);
        offer_op(OP_INSERT, 7'd2,   32'sd5);
        offer_op(OP_INSERT, 7'd1,   32'sh8000_0000);
        offer_op(OP_INSERT, 7'd2,   32'sh7FFF_FFFF);
        offer_op(OP_INSERT, 7'd1,   32'sd0);
        offer_op(OP_INSERT, 7'd4,   32'sh7FFF_FFFF);
        offer_op(OP_INSERT, 7'd127, 32'sd9);
        offer_op(OP_LOCATE, 7'd0,   32'sh7FFF_FFFF);
        offer_op(OP_LOCATE, 7'd127, -32'sd1);
        offer_op(OP_GET,    7'd0,   32'sd0);
        offer_op(OP_GET,    7'd4,   32'sd0);
        offer_op(OP_GET,    7'd5,   32'sd0);
        offer_op(OP_GET,    7'd127, 32'sd0);
        offer_op(OP_DELETE, 7'd127, 32'sd0);
        offer_op(OP_DELETE, 7'd0,   32'sd0);
        offer_op(OP_DELETE, 7'd2,   32'sd0);
        offer_op(OP_INSERT, 7'd3,   32'sh5555_5555);
        offer_op(OP_DELETE, 7'd1,   32'sd0);
        offer_op(OP_GET,    7'd2,   32'sd0);
        offer_op(OP_LOCATE, 7'd1,   32'shAAAA_AAAA);
        offer_op(OP_DELETE, 7'd3,   32'sd0);
        wait_list_idle();

        set_register(REG_MAX_ENTRIES, 32'd0);
        run_random(10, 60, -1, -1);
        wait_list_idle();

        set_register(REG_MAX_ENTRIES, 32'd1);
        run_random(60, 50, -1, -1);
        wait_list_idle();

        set_register(REG_MAX_ENTRIES, 32'd127);
        run_random(400, 60, 100, -1);
        wait_list_idle();

        // limit below the current length
        send_idle_pct = 84;
        recv_idle_pct = 27;
        set_register(REG_MAX_ENTRIES, 32'd10);
        run_random(150, 30, -1, -1);
        wait_list_idle();

        // unmapped register must leave the limit alone
        set_register(REG_UNUSED, 32'h0000_0003);
        run_random(250, 50, -1, -1);
        wait_list_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_register(REG_MAX_ENTRIES, 32'd64);
        run_random(400, 55, 150, 200);
        wait_list_idle();

        set_register(REG_MAX_ENTRIES, 32'($urandom_range(63, 2)));
        run_random(280, 50, -1, -1);
        wait_list_idle();

        $display("Ran %0d list operations (%0d insert, %0d delete, %0d locate, %0d get),",
                 book.checked, book.op_count[OP_INSERT], book.op_count[OP_DELETE],
                 book.op_count[OP_LOCATE], book.op_count[OP_GET]);
        $display("%0d succeeded; list peaked at %0d entries; max_entries went 64, 0, 1, 127, %s",
                 book.ok_count, book.peak, $sformatf("10, 64, %0d.", last_limit));
        if (book.mismatches == 0)
            $display("PASS positional_list_insert_delete_unit");
        else
            $display("FAIL positional_list_insert_delete_unit");
        $finish;
    end

endmodule
